[src/quantized_atan2_bisection_top_defines.svh]
// Assertion macros shared by the angle quantizer.
`ifndef QUANTIZED_ATAN2_BISECTION_TOP_DEFINES_SVH
`define QUANTIZED_ATAN2_BISECTION_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define QAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define QAB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define QAB_ASSERT(lbl, prop, msg)

`define QAB_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

[src/qab_pkg.sv]
`default_nettype none

package qab_pkg;

  localparam int unsigned BISECT_STEPS_DEF = 9;
  localparam int unsigned COORD_WIDTH_DEF  = 16;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned TAYLOR_TERMS     = 10;
  localparam int unsigned TRIG_W           = 31;

  localparam logic [63:0] PI_Q48  = 64'h0003_243F_6A88_85A3;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  localparam logic [63:0] SIN_DIV [1:TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };
  localparam logic [63:0] COS_DIV [1:TAYLOR_TERMS] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
    64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic ax_zero;
    logic ay_zero;
  } item_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [TRIG_W-1:0] clamp_q30(input logic signed [63:0] v);
    if (v < 0) begin
      return '0;
    end
    if (v > $signed(ONE_Q30)) begin
      return TRIG_W'(ONE_Q30);
    end
    return v[TRIG_W-1:0];
  endfunction

  // Sine or cosine of threshold m * pi / 2^(steps+1) in Q30 by a truncated Taylor series.
  function automatic logic [TRIG_W-1:0] thr_trig(input logic [63:0] m,
                                                 input int unsigned steps,
                                                 input logic want_cos);
    logic [63:0]        th;
    logic [63:0]        th2;
    logic [63:0]        ts;
    logic [63:0]        tc;
    logic signed [63:0] s;
    logic signed [63:0] c;
    th  = (m * PI_Q48) >> (steps + 19);
    th2 = (th * th) >> 30;
    ts  = th;
    tc  = ONE_Q30;
    s   = $signed(th);
    c   = $signed(ONE_Q30);
    for (int n = 1; n <= int'(TAYLOR_TERMS); n++) begin
      ts = ((ts * th2) >> 30) / SIN_DIV[n];
      tc = ((tc * th2) >> 30) / COS_DIV[n];
      if (n[0]) begin
        s = s - $signed(ts);
        c = c - $signed(tc);
      end else begin
        s = s + $signed(ts);
        c = c + $signed(tc);
      end
    end
    return want_cos ? clamp_q30(c) : clamp_q30(s);
  endfunction

endpackage

`default_nettype wire

[src/qab_front.sv]
`default_nettype none

module qab_front #(
  parameter int unsigned CW = qab_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [CW-1:0]    in_vec_x,
  input  wire logic signed [CW-1:0]    in_vec_y,
  input  wire logic                    q_full,
  output logic                         push_o,
  output qab_pkg::item_ctrl_t          ctrl_o,
  output logic [CW-1:0]                ax_o,
  output logic [CW-1:0]                ay_o
);

  logic                 f_valid_r;
  qab_pkg::item_ctrl_t  ctrl_r;
  qab_pkg::item_ctrl_t  ctrl_nxt;
  logic [CW-1:0]        ax_r;
  logic [CW-1:0]        ay_r;
  logic [CW-1:0]        ax_nxt;
  logic [CW-1:0]        ay_nxt;
  logic                 front_go;

  assign front_go = !f_valid_r || !q_full;
  assign in_stall = !front_go;
  assign push_o   = f_valid_r && !q_full;

  // Fold the vector into the first quadrant and flag the axis cases.
  always_comb begin
    ax_nxt           = in_vec_x[CW-1] ? CW'(~in_vec_x + 1'b1) : CW'(in_vec_x);
    ay_nxt           = in_vec_y[CW-1] ? CW'(~in_vec_y + 1'b1) : CW'(in_vec_y);
    ctrl_nxt.neg_x   = in_vec_x[CW-1];
    ctrl_nxt.neg_y   = in_vec_y[CW-1];
    ctrl_nxt.ax_zero = (in_vec_x == '0);
    ctrl_nxt.ay_zero = (in_vec_y == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (front_go) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_go && in_valid) begin
      ctrl_r <= ctrl_nxt;
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
    end
  end

  assign ctrl_o = ctrl_r;
  assign ax_o   = ax_r;
  assign ay_o   = ay_r;

endmodule

`default_nettype wire

[src/qab_queue.sv]
`default_nettype none

module qab_queue #(
  parameter int unsigned CW    = qab_pkg::COORD_WIDTH_DEF,
  parameter int unsigned DEPTH = qab_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire qab_pkg::item_ctrl_t  ctrl_i,
  input  wire logic [CW-1:0]        ax_i,
  input  wire logic [CW-1:0]        ay_i,
  input  wire logic                 pop,
  output qab_pkg::item_ctrl_t       ctrl_o,
  output logic [CW-1:0]             ax_o,
  output logic [CW-1:0]             ay_o,
  output qab_pkg::queue_stat_t      stat_o
);

  localparam int unsigned PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  qab_pkg::item_ctrl_t ctrl_mem [DEPTH];
  logic [CW-1:0]       ax_mem   [DEPTH];
  logic [CW-1:0]       ay_mem   [DEPTH];
  logic [PTRW-1:0]     wr_ptr_r;
  logic [PTRW-1:0]     rd_ptr_r;
  logic [PTRW-1:0]     rd_ptr_nxt;
  logic [CNTW-1:0]     count_r;
  logic                do_push;
  logic                do_pop;
  logic                head_bypass;
  qab_pkg::item_ctrl_t ctrl_head_r;
  logic [CW-1:0]       ax_head_r;
  logic [CW-1:0]       ay_head_r;

  assign stat_o.full  = (count_r == CNTW'(DEPTH));
  assign stat_o.empty = (count_r == '0);
  assign do_push      = push && !stat_o.full;
  assign do_pop       = pop && !stat_o.empty;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  // The head entry is held in registers; a push into the slot being read goes straight through.
  assign head_bypass = do_push && (wr_ptr_r == rd_ptr_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      rd_ptr_r <= rd_ptr_nxt;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ctrl_mem[wr_ptr_r] <= ctrl_i;
      ax_mem[wr_ptr_r]   <= ax_i;
      ay_mem[wr_ptr_r]   <= ay_i;
    end
  end

  always_ff @(posedge clk) begin
    if (head_bypass) begin
      ctrl_head_r <= ctrl_i;
      ax_head_r   <= ax_i;
      ay_head_r   <= ay_i;
    end else begin
      ctrl_head_r <= ctrl_mem[rd_ptr_nxt];
      ax_head_r   <= ax_mem[rd_ptr_nxt];
      ay_head_r   <= ay_mem[rd_ptr_nxt];
    end
  end

  assign ctrl_o = ctrl_head_r;
  assign ax_o   = ax_head_r;
  assign ay_o   = ay_head_r;

endmodule

`default_nettype wire

[src/qab_step.sv]
`default_nettype none

module qab_step #(
  parameter int unsigned STEPS = qab_pkg::BISECT_STEPS_DEF,
  parameter int unsigned CW    = qab_pkg::COORD_WIDTH_DEF,
  parameter int unsigned IDX   = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 valid_i,
  input  wire qab_pkg::item_ctrl_t  ctrl_i,
  input  wire logic [CW-1:0]        ax_i,
  input  wire logic [CW-1:0]        ay_i,
  input  wire logic [STEPS-1:0]     lo_i,
  output logic                      valid_o,
  output qab_pkg::item_ctrl_t       ctrl_o,
  output logic [CW-1:0]             ax_o,
  output logic [CW-1:0]             ay_o,
  output logic [STEPS-1:0]          lo_o
);

  localparam int unsigned TW = qab_pkg::TRIG_W;
  localparam int unsigned PW = CW + TW;
  localparam logic [STEPS-1:0] MID_BIT = STEPS'(1) << (STEPS - 1 - IDX);

  logic [TW-1:0]        s_sel;
  logic [TW-1:0]        c_sel;
  logic                 valid_a_r;
  logic                 valid_b_r;
  qab_pkg::item_ctrl_t  ctrl_a_r;
  qab_pkg::item_ctrl_t  ctrl_b_r;
  logic [CW-1:0]        ax_a_r;
  logic [CW-1:0]        ay_a_r;
  logic [CW-1:0]        ax_b_r;
  logic [CW-1:0]        ay_b_r;
  logic [STEPS-1:0]     lo_a_r;
  logic [STEPS-1:0]     lo_b_r;
  logic [PW-1:0]        prod_x_r;
  logic [PW-1:0]        prod_y_r;

  // The first threshold is pi/4, where the test reduces to y >= x.
  if (IDX == 0) begin : g_diag
    localparam logic [TW-1:0] UNIT = TW'(1);
    assign s_sel = UNIT;
    assign c_sel = UNIT;
  end else begin : g_tab
    localparam int unsigned N = 1 << IDX;
    logic [TW-1:0]  sin_tab [N];
    logic [TW-1:0]  cos_tab [N];
    logic [IDX-1:0] tix;
    for (genvar j = 0; j < N; j++) begin : g_ent
      localparam logic [63:0] MID   = ((64'(j) << 1) | 64'd1) << (STEPS - 1 - IDX);
      localparam logic [TW-1:0] SV  = qab_pkg::thr_trig(MID, STEPS, 1'b0);
      localparam logic [TW-1:0] CV  = qab_pkg::thr_trig(MID, STEPS, 1'b1);
      assign sin_tab[j] = SV;
      assign cos_tab[j] = CV;
    end
    assign tix   = lo_i[STEPS-1 -: IDX];
    assign s_sel = sin_tab[tix];
    assign c_sel = cos_tab[tix];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else if (adv) begin
      valid_a_r <= valid_i;
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_y_r <= PW'(ay_i) * PW'(c_sel);
      prod_x_r <= PW'(ax_i) * PW'(s_sel);
      ctrl_a_r <= ctrl_i;
      ax_a_r   <= ax_i;
      ay_a_r   <= ay_i;
      lo_a_r   <= lo_i;
      lo_b_r   <= (prod_y_r >= prod_x_r) ? (lo_a_r | MID_BIT) : lo_a_r;
      ctrl_b_r <= ctrl_a_r;
      ax_b_r   <= ax_a_r;
      ay_b_r   <= ay_a_r;
    end
  end

  assign valid_o = valid_b_r;
  assign ctrl_o  = ctrl_b_r;
  assign ax_o    = ax_b_r;
  assign ay_o    = ay_b_r;
  assign lo_o    = lo_b_r;

endmodule

`default_nettype wire

[src/qab_back.sv]
`default_nettype none

module qab_back #(
  parameter int unsigned STEPS = qab_pkg::BISECT_STEPS_DEF,
  parameter int unsigned CW    = qab_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 valid_i,
  input  wire qab_pkg::item_ctrl_t  ctrl_i,
  input  wire logic [CW-1:0]        ax_i,
  input  wire logic [CW-1:0]        ay_i,
  output logic                      take_o,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [STEPS+2:0]          out_angle_code
);

  localparam int unsigned AW = STEPS + 3;
  localparam logic [AW-1:0] QUARTER = AW'(1) << (STEPS + 1);
  localparam logic [AW-1:0] HALF    = AW'(1) << (STEPS + 2);

  logic                 valid_c [STEPS+1];
  qab_pkg::item_ctrl_t  ctrl_c  [STEPS+1];
  logic [CW-1:0]        ax_c    [STEPS];
  logic [CW-1:0]        ay_c    [STEPS];
  logic [STEPS-1:0]     lo_c    [STEPS+1];
  logic                 adv;
  logic                 out_valid_r;
  logic [AW-1:0]        out_angle_r;
  logic [AW-1:0]        angle_nxt;

  assign adv     = !out_valid_r || !out_stall;
  assign take_o  = adv;

  assign valid_c[0] = valid_i;
  assign ctrl_c[0]  = ctrl_i;
  assign ax_c[0]    = ax_i;
  assign ay_c[0]    = ay_i;
  assign lo_c[0]    = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    if (k == STEPS - 1) begin : g_last
      qab_step #(.STEPS(STEPS), .CW(CW), .IDX(k)) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .valid_i (valid_c[k]),
        .ctrl_i  (ctrl_c[k]),
        .ax_i    (ax_c[k]),
        .ay_i    (ay_c[k]),
        .lo_i    (lo_c[k]),
        .valid_o (valid_c[k+1]),
        .ctrl_o  (ctrl_c[k+1]),
        .ax_o    (),
        .ay_o    (),
        .lo_o    (lo_c[k+1])
      );
    end else begin : g_mid
      qab_step #(.STEPS(STEPS), .CW(CW), .IDX(k)) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .valid_i (valid_c[k]),
        .ctrl_i  (ctrl_c[k]),
        .ax_i    (ax_c[k]),
        .ay_i    (ay_c[k]),
        .lo_i    (lo_c[k]),
        .valid_o (valid_c[k+1]),
        .ctrl_o  (ctrl_c[k+1]),
        .ax_o    (ax_c[k+1]),
        .ay_o    (ay_c[k+1]),
        .lo_o    (lo_c[k+1])
      );
    end
  end

  // Center of the final interval (or the axis angle), then undo the quadrant folding.
  always_comb begin
    angle_nxt = {2'b00, lo_c[STEPS], 1'b1};
    if (ctrl_c[STEPS].ax_zero) begin
      angle_nxt = QUARTER;
    end else if (ctrl_c[STEPS].ay_zero) begin
      angle_nxt = '0;
    end
    if (ctrl_c[STEPS].neg_x) begin
      angle_nxt = HALF - angle_nxt;
    end
    if (ctrl_c[STEPS].neg_y) begin
      angle_nxt = (~angle_nxt) + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= valid_c[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_angle_r <= angle_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_angle_code = out_angle_r;

endmodule

`default_nettype wire

[src/quantized_atan2_bisection_top.sv]
// Throughput: one vector per cycle when neither in_stall nor out_stall is raised;
// each bisection step is a lookup-and-multiply stage followed by a compare stage,
// and the step pipeline moves as one unit.
// Reset clears the valid flags, the queue pointers and the output register valid.
// The threshold tables are constants and need no initialization.
`default_nettype none

`include "quantized_atan2_bisection_top_defines.svh"

module quantized_atan2_bisection_top #(
  parameter int unsigned BISECT_STEPS = qab_pkg::BISECT_STEPS_DEF,
  parameter int unsigned COORD_WIDTH  = qab_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_vec_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_vec_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [BISECT_STEPS+2:0]            out_angle_code
);

  qab_pkg::item_ctrl_t   f_ctrl;
  logic [COORD_WIDTH-1:0] f_ax;
  logic [COORD_WIDTH-1:0] f_ay;
  logic                  f_push;
  qab_pkg::item_ctrl_t   q_ctrl;
  logic [COORD_WIDTH-1:0] q_ax;
  logic [COORD_WIDTH-1:0] q_ay;
  qab_pkg::queue_stat_t  q_stat;
  logic                  b_take;

  qab_front #(.CW(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_vec_x (in_vec_x),
    .in_vec_y (in_vec_y),
    .q_full   (q_stat.full),
    .push_o   (f_push),
    .ctrl_o   (f_ctrl),
    .ax_o     (f_ax),
    .ay_o     (f_ay)
  );

  qab_queue #(.CW(COORD_WIDTH), .DEPTH(qab_pkg::QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (f_push),
    .ctrl_i (f_ctrl),
    .ax_i   (f_ax),
    .ay_i   (f_ay),
    .pop    (b_take),
    .ctrl_o (q_ctrl),
    .ax_o   (q_ax),
    .ay_o   (q_ay),
    .stat_o (q_stat)
  );

  qab_back #(.STEPS(BISECT_STEPS), .CW(COORD_WIDTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid_i        (!q_stat.empty),
    .ctrl_i         (q_ctrl),
    .ax_i           (q_ax),
    .ay_i           (q_ay),
    .take_o         (b_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_angle_code (out_angle_code)
  );

  `QAB_ASSERT(a_queue_flags, !(q_stat.full && q_stat.empty), "queue is full and empty at once")
  `QAB_ASSERT_NEXT(a_queue_idle, q_stat.empty && !f_push, q_stat.empty, "queue filled without a push")
  `QAB_ASSERT_NEXT(a_queue_drain, q_stat.full, !q_stat.empty, "full queue emptied in one cycle")

endmodule

`default_nettype wire

[tb/tb_top.sv]
module tb_top;

  localparam int STEPS       = 9;
  localparam int CW          = 16;
  localparam int AW          = STEPS + 3;
  localparam int NUM_THR     = (1 << STEPS) - 1;
  localparam int TERMS       = 10;
  localparam int LATENCY     = 2 * STEPS + 3;
  localparam int HOLD_CYCLES = 250;
  localparam int IDLE_PCT    = 37;

  localparam logic [63:0] PI_Q48_CONST = 64'h0003_243F_6A88_85A3;
  localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
  localparam longint QUARTER_CODE = longint'(1) << (STEPS + 1);
  localparam longint HALF_CODE    = longint'(1) << (STEPS + 2);
  localparam longint FULL_CODE    = longint'(1) << (STEPS + 3);

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [AW-1:0]        angle;
  } pending_angle_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic signed [CW-1:0] in_vec_x  = '0;
  logic signed [CW-1:0] in_vec_y  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [AW-1:0]        out_angle_code;

  logic [63:0]    ray_sin_q30 [1:NUM_THR];
  logic [63:0]    ray_cos_q30 [1:NUM_THR];
  pending_angle_t pending_angles [$];
  int             mismatch_count = 0;
  bit             tx_idle_on     = 1'b1;
  bit             rx_idle_on     = 1'b1;
  bit             hold_request   = 1'b0;

  quantized_atan2_bisection_top #(
    .BISECT_STEPS(STEPS),
    .COORD_WIDTH (CW)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_vec_x      (in_vec_x),
    .in_vec_y      (in_vec_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_angle_code(out_angle_code)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] clamp_unit(input longint v);
    if (v < 0) begin
      return 64'd0;
    end
    if (v > longint'(Q30_ONE)) begin
      return Q30_ONE;
    end
    return 64'(v);
  endfunction

  function automatic void build_ray_table();
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] sin_term;
    logic [63:0] cos_term;
    logic [63:0] k;
    longint      sin_acc;
    longint      cos_acc;
    for (int m = 1; m <= NUM_THR; m++) begin
      th       = (64'(m) * PI_Q48_CONST) >> (STEPS + 19);
      th2      = (th * th) >> 30;
      sin_term = th;
      cos_term = Q30_ONE;
      sin_acc  = longint'(th);
      cos_acc  = longint'(Q30_ONE);
      for (int n = 1; n <= TERMS; n++) begin
        k        = 64'(n);
        sin_term = ((sin_term * th2) >> 30) / ((2 * k) * (2 * k + 1));
        cos_term = ((cos_term * th2) >> 30) / ((2 * k - 1) * (2 * k));
        if (n % 2 == 1) begin
          sin_acc -= longint'(sin_term);
          cos_acc -= longint'(cos_term);
        end else begin
          sin_acc += longint'(sin_term);
          cos_acc += longint'(cos_term);
        end
      end
      ray_sin_q30[m] = clamp_unit(sin_acc);
      ray_cos_q30[m] = clamp_unit(cos_acc);
    end
  endfunction

  function automatic longint quadrant_code(input longint ax, input longint ay);
    int     lo;
    int     mid;
    bit     up;
    if (ax == 0) begin
      return QUARTER_CODE;
    end
    if (ay == 0) begin
      return 0;
    end
    lo = 0;
    for (int i = 0; i < STEPS; i++) begin
      mid = lo + (1 << (STEPS - 1 - i));
      if (mid == (1 << (STEPS - 1))) begin
        up = (ay >= ax);
      end else begin
        up = (64'(ay) * ray_cos_q30[mid]) >= (64'(ax) * ray_sin_q30[mid]);
      end
      if (up) begin
        lo = mid;
      end
    end
    return 2 * longint'(lo) + 1;
  endfunction

  function automatic longint upper_half_code(input longint x, input longint ay);
    if (x < 0) begin
      return HALF_CODE - quadrant_code(-x, ay);
    end
    return quadrant_code(x, ay);
  endfunction

  function automatic logic [AW-1:0] predict_angle_code(input logic signed [CW-1:0] x,
                                                       input logic signed [CW-1:0] y);
    longint xs;
    longint ys;
    longint code;
    xs = x;
    ys = y;
    if (ys < 0) begin
      code = FULL_CODE - upper_half_code(xs, -ys);
    end else begin
      code = upper_half_code(xs, ys);
    end
    return code[AW-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  task automatic send_vector(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
    pending_angle_t entry;
    while (tx_idle_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vec_x <= x;
    in_vec_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    entry.x     = x;
    entry.y     = y;
    entry.angle = predict_angle_code(x, y);
    pending_angles.push_back(entry);
  endtask

  task automatic gen_random_vector(output logic signed [CW-1:0] x,
                                   output logic signed [CW-1:0] y);
    int     kind;
    int     m;
    longint r;
    longint vx;
    longint vy;
    kind = $urandom_range(9);
    if (kind <= 3) begin
      x = CW'($urandom());
      y = CW'($urandom());
    end else if (kind <= 6) begin
      m  = $urandom_range(1, NUM_THR);
      r  = $urandom_range(1, 32766);
      vx = longint'((ray_cos_q30[m] * 64'(r)) >> 30) + $urandom_range(2) - 1;
      vy = longint'((ray_sin_q30[m] * 64'(r)) >> 30) + $urandom_range(2) - 1;
      if (vx < 0) vx = 0;
      if (vy < 0) vy = 0;
      x  = $urandom_range(1) ? CW'(-vx) : CW'(vx);
      y  = $urandom_range(1) ? CW'(-vy) : CW'(vy);
    end else if (kind == 7) begin
      x = CW'(int'($urandom_range(16)) - 8);
      y = CW'(int'($urandom_range(16)) - 8);
    end else if (kind == 8) begin
      x = CW'($urandom());
      y = '0;
      if ($urandom_range(1)) begin
        y = x;
        x = '0;
      end
    end else begin
      vx = $urandom_range(1, 32767);
      x  = $urandom_range(1) ? CW'(-vx) : CW'(vx);
      y  = $urandom_range(1) ? CW'(-vx) : CW'(vx);
    end
  endtask

  task automatic test_directed_corners();
    int dir_x [23] = '{0, 1, 0, -1, 0, 32767, -32768, 0, 0, 1, 32767, -32768, -32768,
                       32767, -1, 1, 32767, 1, -32768, -1, 12345, -20000, 3};
    int dir_y [23] = '{0, 0, 1, 0, -1, 0, 0, 32767, -32768, 1, 32767, -32768, 32767,
                       -32768, 1, -1, 1, 32767, -1, -32768, -6789, 15000, -3};
    for (int i = 0; i < 23; i++) begin
      send_vector(CW'(dir_x[i]), CW'(dir_y[i]));
    end
  endtask

  task automatic test_random_vectors(input int count);
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    for (int i = 0; i < count; i++) begin
      gen_random_vector(x, y);
      send_vector(x, y);
    end
  endtask

  task automatic test_full_rate();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_vectors(150);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_idle_on   = 1'b0;
    hold_request = 1'b1;
    test_random_vectors(80);
    tx_idle_on   = 1'b1;
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : check_results
    pending_angle_t head;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_angles.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, angle %0d", out_angle_code));
      end else begin
        head = pending_angles.pop_front();
        if (out_angle_code !== head.angle) begin
          report_mismatch($sformatf("x=%0d y=%0d: angle %0d, expected %0d",
                                    head.x, head.y, out_angle_code, head.angle));
        end
      end
    end
  end

  initial begin
    build_ray_table();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_random_vectors(350);
    test_full_rate();
    test_backpressure();
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("quantized_atan2_bisection_top test passed");
    end else begin
      $display("quantized_atan2_bisection_top test failed");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("quantized_atan2_bisection_top test failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/qab_pkg.sv
src/qab_front.sv
src/qab_queue.sv
src/qab_step.sv
src/qab_back.sv
src/quantized_atan2_bisection_top.sv
tb/tb_top.sv
